// ===== src/time_bucket_alert_merger_macros.svh =====
// assertion macros used by the rtl file tbam_ctrl
`ifndef TIME_BUCKET_ALERT_MERGER_MACROS_SVH
`define TIME_BUCKET_ALERT_MERGER_MACROS_SVH

// property that holds whenever reset is low
`define TBAM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define TBAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tbam_pkg.sv =====
// ----------------------------------------------------------------------------
// tbam_pkg
// types, constants and helpers for the time bucket alert merger
// ----------------------------------------------------------------------------
package tbam_pkg;

  localparam int NUM_BUCKETS_DEF = 16;
  localparam int MAX_RESULTS = 16;
  localparam logic [31:0] BUCKET_LEN_RESET = 32'd50000;

  localparam logic OP_ALERT = 1'b0;
  localparam logic OP_TICK  = 1'b1;
  localparam logic KIND_MERGED = 1'b0;
  localparam logic KIND_DROP   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [39:0] time_us;
    logic [1:0]  decision_code;
    logic [15:0] prob_raw;
    logic [15:0] prob_cal;
    logic [31:0] latency_us;
    logic        escalate;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [39:0] bucket_id;
    logic [1:0]  merged_decision;
    logic [15:0] merged_prob_raw;
    logic [15:0] merged_prob_cal;
    logic [40:0] end_to_end_us;
    logic        merged_escalate;
    logic [39:0] winner_time_us;
    logic [15:0] bucket_size;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SCAN, ST_APPLY, ST_DROP, ST_FSCAN, ST_FEMIT, ST_FWAIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture input item, reset scan
    logic div_step;   // one quotient bit
    logic scan_step;  // examine one slot
    logic scan_clr;   // restart slot scan
    logic apply;      // merge or allocate
    logic make_drop;  // build drop result
    logic make_emit;  // build merged result from best, free it
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_tick;
    logic div_done;
    logic scan_done;
    logic hit;
    logic has_free;
    logic has_best;
  } stat_t;

  // decision rank: unknown lowest
  function automatic logic [1:0] rank_of(input logic [1:0] code);
    return code + 2'd1;
  endfunction

endpackage

// ===== src/tbam_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbam_ctrl
// sequencer: divide, scan, merge or drop, and flush emit loop
// ----------------------------------------------------------------------------
`include "time_bucket_alert_merger_macros.svh"
module tbam_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tbam_pkg::stat_t stat,
  output tbam_pkg::cmd_t  cmd,
  output logic            out_last_sel
);
  import tbam_pkg::*;

  state_t state, state_next;
  logic [4:0] n_emit, n_emit_next;
  logic       ov, ov_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_DIV;
      ST_DIV:   if (stat.div_done) state_next = stat.is_tick ? ST_FSCAN : ST_SCAN;
      ST_SCAN:  if (stat.scan_done) begin
        if (stat.hit || stat.has_free) state_next = ST_APPLY;
        else state_next = ST_DROP;
      end
      ST_APPLY: state_next = ST_IDLE;
      ST_DROP:  state_next = ST_FWAIT;
      ST_FSCAN: if (stat.scan_done) begin
        if (stat.has_best && n_emit < 5'(MAX_RESULTS)) state_next = ST_FEMIT;
        else if (ov) state_next = ST_FWAIT;
        else state_next = ST_IDLE;
      end
      ST_FEMIT: if (!ov || out_ready) state_next = ST_FSCAN;
      ST_FWAIT: if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // one result is held back so last can be set on the final one
  always_comb begin
    n_emit_next = n_emit;
    ov_next = ov;
    if (state == ST_IDLE) n_emit_next = '0;
    if (ov && out_ready && (state == ST_FWAIT || state == ST_FEMIT)) ov_next = 1'b0;
    if (state == ST_DROP) ov_next = 1'b1;
    if (state == ST_FEMIT && (!ov || out_ready)) begin
      ov_next = 1'b1;
      n_emit_next = n_emit + 5'd1;
    end
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = (state == ST_IDLE);
    cmd.load = (state == ST_IDLE) && in_valid;
    cmd.div_step = (state == ST_DIV);
    cmd.scan_step = (state == ST_SCAN) || (state == ST_FSCAN);
    cmd.scan_clr = (state == ST_FEMIT) && (!ov || out_ready);
    cmd.apply = (state == ST_APPLY);
    cmd.make_drop = (state == ST_DROP);
    cmd.make_emit = cmd.scan_clr;
    // shown valid only when it is known whether another follows
    out_valid = ov && (state == ST_FWAIT || state == ST_FEMIT);
    // held result turns out to be the final one of the tick
    out_last_sel = (state == ST_FSCAN) && stat.scan_done && ov &&
                   !(stat.has_best && n_emit < 5'(MAX_RESULTS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n_emit <= '0;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      n_emit <= n_emit_next;
      ov <= ov_next;
    end
  end

  `TBAM_ASSERT(a_no_accept_busy, !(in_ready && out_valid), "input taken while result pending")
  `TBAM_ASSERT(a_emit_cap, n_emit <= 5'(MAX_RESULTS), "too many results")
  `TBAM_ASSERT_NEXT(a_drop_ov, state == ST_DROP, ov, "drop result lost")
endmodule

// ===== src/tbam_dp.sv =====
// ----------------------------------------------------------------------------
// tbam_dp
// datapath: serial divider, slot table, scan unit and result register
// ----------------------------------------------------------------------------
module tbam_dp #(
  parameter int NUM_BUCKETS = tbam_pkg::NUM_BUCKETS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  input  tbam_pkg::in_item_t  in_item,
  input  tbam_pkg::cmd_t      cmd,
  input  logic                out_last_sel,
  output tbam_pkg::stat_t     stat,
  output tbam_pkg::out_item_t out_item
);
  import tbam_pkg::*;

  localparam int IW = $clog2(NUM_BUCKETS);
  localparam int CW = $clog2(NUM_BUCKETS + 1);

  logic [31:0] blen;
  in_item_t    cur;

  // divider
  logic [39:0] quo;
  logic [31:0] rem;
  logic [5:0]  dcnt;
  logic [32:0] rem_sh, rem_sub;
  logic [31:0] dlen;

  // slot table
  logic [NUM_BUCKETS-1:0] sv;
  logic [39:0] s_bucket [NUM_BUCKETS];
  logic [1:0]  s_dec    [NUM_BUCKETS];
  logic [15:0] s_pcal   [NUM_BUCKETS];
  logic [15:0] s_praw   [NUM_BUCKETS];
  logic [31:0] s_lat    [NUM_BUCKETS];
  logic [39:0] s_stamp  [NUM_BUCKETS];
  logic        s_esc    [NUM_BUCKETS];
  logic [15:0] s_cnt    [NUM_BUCKETS];

  // scan
  logic [CW-1:0] sc;
  logic [IW-1:0] si, hit_i, free_i, best_i;
  logic          hit, has_free, has_best;
  logic [41:0]   sum;
  logic          win;

  assign dlen = (blen == 32'd0) ? 32'd1 : blen;
  assign rem_sh = {rem, quo[39]};
  assign rem_sub = rem_sh - {1'b0, dlen};
  assign si = sc[IW-1:0];

  assign stat.is_tick = cur.operation == OP_TICK;
  assign stat.div_done = dcnt == 6'd40;
  assign stat.scan_done = sc == CW'(NUM_BUCKETS);
  assign stat.hit = hit;
  assign stat.has_free = has_free;
  assign stat.has_best = has_best;

  // config register
  always_ff @(posedge clk) begin
    if (rst) blen <= BUCKET_LEN_RESET;
    else if (cfg_we) blen <= cfg_data;
  end

  // restoring divider, quotient shifts in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= in_item;
      quo <= in_item.time_us;
      rem <= '0;
      dcnt <= '0;
    end else if (cmd.div_step && dcnt != 6'd40) begin
      dcnt <= dcnt + 6'd1;
      if (!rem_sub[32]) begin
        rem <= rem_sub[31:0];
        quo <= {quo[38:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[38:0], 1'b0};
      end
    end
  end

  // slot scan: hit, lowest free slot, lowest due bucket
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.scan_clr) begin
      sc <= '0;
      hit <= 1'b0;
      has_free <= 1'b0;
      has_best <= 1'b0;
    end else if (cmd.scan_step && !stat.scan_done) begin
      sc <= sc + CW'(1);
      if (sv[si]) begin
        if (!hit && s_bucket[si] == quo) begin
          hit <= 1'b1;
          hit_i <= si;
        end
        if (s_bucket[si] <= quo && (!has_best || s_bucket[si] < s_bucket[best_i])) begin
          has_best <= 1'b1;
          best_i <= si;
        end
      end else if (!has_free) begin
        has_free <= 1'b1;
        free_i <= si;
      end
    end
  end

  assign win = (rank_of(cur.decision_code) > rank_of(s_dec[hit_i])) ||
               (rank_of(cur.decision_code) == rank_of(s_dec[hit_i]) &&
                cur.prob_cal > s_pcal[hit_i]);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) sv <= '0;
    else if (cmd.apply && !hit) sv[free_i] <= 1'b1;
    else if (cmd.make_emit) sv[best_i] <= 1'b0;
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (hit) begin
        if (win) begin
          s_dec[hit_i] <= cur.decision_code;
          s_praw[hit_i] <= cur.prob_raw;
          s_pcal[hit_i] <= cur.prob_cal;
          s_lat[hit_i] <= cur.latency_us;
          s_stamp[hit_i] <= cur.time_us;
        end
        s_esc[hit_i] <= s_esc[hit_i] | cur.escalate;
        if (s_cnt[hit_i] != 16'hFFFF) s_cnt[hit_i] <= s_cnt[hit_i] + 16'd1;
      end else begin
        s_bucket[free_i] <= quo;
        s_dec[free_i] <= cur.decision_code;
        s_praw[free_i] <= cur.prob_raw;
        s_pcal[free_i] <= cur.prob_cal;
        s_lat[free_i] <= cur.latency_us;
        s_stamp[free_i] <= cur.time_us;
        s_esc[free_i] <= cur.escalate;
        s_cnt[free_i] <= 16'd1;
      end
    end
  end

  assign sum = {2'b0, cur.time_us} + {10'b0, s_lat[best_i]} - {2'b0, s_stamp[best_i]};

  // result register, last marked once the held result is known to be final
  always_ff @(posedge clk) begin
    if (cmd.make_drop) begin
      out_item.kind <= KIND_DROP;
      out_item.bucket_id <= quo;
      out_item.merged_decision <= cur.decision_code;
      out_item.merged_prob_raw <= cur.prob_raw;
      out_item.merged_prob_cal <= cur.prob_cal;
      out_item.end_to_end_us <= '0;
      out_item.merged_escalate <= cur.escalate;
      out_item.winner_time_us <= cur.time_us;
      out_item.bucket_size <= '0;
      out_item.last <= 1'b1;
    end else if (cmd.make_emit) begin
      out_item.kind <= KIND_MERGED;
      out_item.bucket_id <= s_bucket[best_i];
      out_item.merged_decision <= s_dec[best_i];
      out_item.merged_prob_raw <= s_praw[best_i];
      out_item.merged_prob_cal <= s_pcal[best_i];
      out_item.end_to_end_us <= sum[41] ? 41'd0 : sum[40:0];
      out_item.merged_escalate <= s_esc[best_i];
      out_item.winner_time_us <= s_stamp[best_i];
      out_item.bucket_size <= s_cnt[best_i];
      out_item.last <= 1'b0;
    end else if (out_last_sel) begin
      out_item.last <= 1'b1;
    end
  end
endmodule

// ===== src/time_bucket_alert_merger.sv =====
// ----------------------------------------------------------------------------
// time_bucket_alert_merger
// merges alerts into time buckets and flushes due buckets on a tick
// ----------------------------------------------------------------------------
// usage:
//   in / in_valid / in_ready carry an alert (operation 0) or a flush tick
//   (operation 1); out / out_valid / out_ready carry result items.
//   the bucket length is written through cfg_we / cfg_data; the user must
//   write it only while idle, and the block itself does not enforce this.
// every item first runs a 40-step serial divide for its bucket id, then a
//   one-slot-per-cycle scan of NUM_BUCKETS slots; an alert that finds no
//   hit and no free slot offers a drop result when its scan is done.
// a tick scans once per emitted bucket and once more, with an emit step
//   between scans; it offers up to 16 items in ascending bucket order,
//   last on the final.
// the block takes one item at a time; in_ready is high only in idle.
// reset clears all slot valid bits and sets the bucket length to 50000.
// a stalled receiver holds the current result; the scan waits behind it.
// ----------------------------------------------------------------------------
module time_bucket_alert_merger #(
  parameter int NUM_BUCKETS = tbam_pkg::NUM_BUCKETS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  input  tbam_pkg::in_item_t  in,
  input  logic                in_valid,
  output logic                in_ready,
  output tbam_pkg::out_item_t out,
  output logic                out_valid,
  input  logic                out_ready
);
  import tbam_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  last_sel;

  tbam_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd, .out_last_sel(last_sel)
  );

  tbam_dp #(.NUM_BUCKETS(NUM_BUCKETS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .in_item(in), .cmd,
    .out_last_sel(last_sel), .stat, .out_item(out)
  );
endmodule

// ===== bench/time_bucket_alert_merger_test.sv =====
// ----------------------------------------------------------------------------
// time_bucket_alert_merger_test
// drives alerts and flush ticks into the bucket merger and scores every
// result item against a cycle-free model of the bucket table or a typed item
// ----------------------------------------------------------------------------
module time_bucket_alert_merger_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tbam_pkg::*;

  localparam int SLOTS = NUM_BUCKETS_DEF;
  localparam logic [39:0] TIME_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [1:0] DEC_NORMAL   = 2'd0;
  localparam logic [1:0] DEC_ATTACK   = 2'd1;
  localparam logic [1:0] DEC_ESCALATE = 2'd2;
  localparam logic [1:0] DEC_UNKNOWN  = 2'd3;
  localparam int USE_MODEL = -1;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_data;
  in_item_t    alert_in;
  logic        in_valid;
  logic        in_ready;
  out_item_t   result_out;
  logic        out_valid;
  logic        out_ready;

  time_bucket_alert_merger dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in(alert_in), .in_valid(in_valid), .in_ready(in_ready),
    .out(result_out), .out_valid(out_valid), .out_ready(out_ready)
  );

  // bucket table model
  logic [31:0] bucket_len;
  bit          slot_used [SLOTS];
  logic [39:0] slot_id [SLOTS];
  logic [1:0]  slot_dec [SLOTS];
  logic [15:0] slot_raw [SLOTS];
  logic [15:0] slot_cal [SLOTS];
  logic [31:0] slot_lat [SLOTS];
  logic [39:0] slot_stamp [SLOTS];
  logic        slot_esc [SLOTS];
  logic [15:0] slot_cnt [SLOTS];

  out_item_t pending_results[$];
  int        errors;
  bit        hold_req;

  // directed table
  typedef struct {
    in_item_t  item;
    int        n_typed;  // USE_MODEL, or number of typed results (0 or 1)
    out_item_t typed;
  } row_t;
  row_t rows[$];

  function automatic logic [1:0] priority_of(logic [1:0] code);
    return code + 2'd1;
  endfunction

  function automatic logic [39:0] bucket_for(logic [39:0] t);
    logic [63:0] len;
    len = (bucket_len == 0) ? 64'd1 : {32'd0, bucket_len};
    return 40'({24'd0, t} / len);
  endfunction

  // apply one item to the table model, return the results it causes
  function automatic void merge_predict(input in_item_t it, ref out_item_t res[$]);
    logic [39:0] id;
    int hit, free_slot, best, n;
    bit wins;
    logic [41:0] sum;
    out_item_t r;
    id = bucket_for(it.time_us);
    if (it.operation == OP_ALERT) begin
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i]) begin
          if (hit < 0 && slot_id[i] == id) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit >= 0) begin
        wins = priority_of(it.decision_code) > priority_of(slot_dec[hit]) ||
               (it.decision_code == slot_dec[hit] && it.prob_cal > slot_cal[hit]);
        if (wins) begin
          slot_dec[hit] = it.decision_code;
          slot_raw[hit] = it.prob_raw;
          slot_cal[hit] = it.prob_cal;
          slot_lat[hit] = it.latency_us;
          slot_stamp[hit] = it.time_us;
        end
        slot_esc[hit] |= it.escalate;
        if (slot_cnt[hit] != 16'hFFFF) slot_cnt[hit]++;
      end else if (free_slot >= 0) begin
        slot_used[free_slot] = 1;
        slot_id[free_slot] = id;
        slot_dec[free_slot] = it.decision_code;
        slot_raw[free_slot] = it.prob_raw;
        slot_cal[free_slot] = it.prob_cal;
        slot_lat[free_slot] = it.latency_us;
        slot_stamp[free_slot] = it.time_us;
        slot_esc[free_slot] = it.escalate;
        slot_cnt[free_slot] = 16'd1;
      end else begin
        r = '{kind: KIND_DROP, bucket_id: id, merged_decision: it.decision_code,
              merged_prob_raw: it.prob_raw, merged_prob_cal: it.prob_cal,
              end_to_end_us: '0, merged_escalate: it.escalate,
              winner_time_us: it.time_us, bucket_size: '0, last: 1'b1};
        res = {res, r};
      end
    end else begin
      n = 0;
      while (n < MAX_RESULTS) begin
        best = -1;
        for (int i = 0; i < SLOTS; i++)
          if (slot_used[i] && slot_id[i] <= id && (best < 0 || slot_id[i] < slot_id[best]))
            best = i;
        if (best < 0) break;
        sum = {2'd0, it.time_us} + {10'd0, slot_lat[best]};
        r = '{kind: KIND_MERGED, bucket_id: slot_id[best], merged_decision: slot_dec[best],
              merged_prob_raw: slot_raw[best], merged_prob_cal: slot_cal[best],
              end_to_end_us: (sum >= {2'd0, slot_stamp[best]}) ?
                             41'(sum - {2'd0, slot_stamp[best]}) : 41'd0,
              merged_escalate: slot_esc[best], winner_time_us: slot_stamp[best],
              bucket_size: slot_cnt[best], last: 1'b0};
        res = {res, r};
        slot_used[best] = 0;
        n++;
      end
      if (n > 0) res[res.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic in_item_t make_item(logic op, logic [39:0] t, logic [1:0] dec,
                                         logic [15:0] raw, logic [15:0] cal,
                                         logic [31:0] lat, logic esc);
    in_item_t it;
    it = '{operation: op, time_us: t, decision_code: dec, prob_raw: raw,
           prob_cal: cal, latency_us: lat, escalate: esc};
    return it;
  endfunction

  function automatic void add_row(in_item_t it, int n_typed, out_item_t typed);
    row_t r;
    r.item = it;
    r.n_typed = n_typed;
    r.typed = typed;
    rows = {rows, r};
  endfunction

  function automatic in_item_t random_item(logic [39:0] base, logic [31:0] len);
    in_item_t it;
    logic [39:0] step;
    step = (len == 0) ? 40'd1 : {8'd0, len};
    it.operation = ($urandom_range(0, 99) < 15) ? OP_TICK : OP_ALERT;
    it.time_us = base + step * 40'($urandom_range(0, 22)) +
                 40'($urandom_range(0, 32'(step - 1)));
    it.decision_code = 2'($urandom);
    it.prob_raw = 16'($urandom);
    it.prob_cal = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    it.latency_us = $urandom;
    it.escalate = ($urandom_range(0, 3) == 0);
    // noise: fully random item
    if ($urandom_range(0, 9) == 0)
      it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom}));
    return it;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("FAIL time_bucket_alert_merger");
    $finish;
  end

  // offer one item after a gap, wait for its handshake, record expectations
  task automatic offer(in_item_t it, int gap, int n_typed, out_item_t typed);
    out_item_t res[$];
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    alert_in = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    merge_predict(it, res);
    if (n_typed == USE_MODEL) begin
      foreach (res[i]) pending_results = {pending_results, res[i]};
    end else if (n_typed == 1) begin
      pending_results = {pending_results, typed};
    end
    @(negedge clk);
  endtask

  // wait until every expected item has arrived, then let the block settle
  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_len(logic [31:0] v);
    cfg_data = v;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    bucket_len = v;
  endtask

  // receiver with random stalls and one long hold-off
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (600) @(negedge clk);
        hold_req = 0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (stall > 0) begin
          out_ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item %p", $realtime, result_out);
        errors++;
      end else if (result_out !== pending_results[0]) begin
        $display("%0t: mismatch expected %p actual %p", $realtime, pending_results[0],
                 result_out);
        errors++;
        void'(pending_results.pop_front());
      end else begin
        void'(pending_results.pop_front());
      end
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    out_item_t none;
    logic [39:0] base;
    logic [31:0] lens [6];
    int gap;
    none = '0;
    errors = 0;
    hold_req = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    alert_in = '0;
    bucket_len = BUCKET_LEN_RESET;
    foreach (slot_used[i]) slot_used[i] = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed rows at the reset bucket length
    add_row(make_item(OP_TICK, 40'd0, DEC_NORMAL, 16'd0, 16'd0, 32'd0, 1'b0), 0, none);
    add_row(make_item(OP_ALERT, 40'd49999, DEC_NORMAL, 16'd1, 16'd100, 32'd0, 1'b0),
            0, none);
    // tick before the winner's time: end to end clamps at zero
    add_row(make_item(OP_TICK, 40'd0, DEC_NORMAL, 16'd0, 16'd0, 32'd0, 1'b0), 1,
            '{KIND_MERGED, 40'd0, DEC_NORMAL, 16'd1, 16'd100, 41'd0, 1'b0, 40'd49999,
              16'd1, 1'b1});
    add_row(make_item(OP_ALERT, 40'd10, DEC_UNKNOWN, 16'hFFFF, 16'hFFFF, 32'd1, 1'b0),
            0, none);
    add_row(make_item(OP_ALERT, 40'd20, DEC_ATTACK, 16'd3, 16'd5, 32'd7, 1'b1), 0, none);
    add_row(make_item(OP_ALERT, 40'd30, DEC_ATTACK, 16'd4, 16'd5, 32'd8, 1'b0), 0, none);
    add_row(make_item(OP_ALERT, 40'd40, DEC_ESCALATE, 16'hFFFF, 16'd0, 32'hFFFF_FFFF, 1'b0),
            0, none);
    add_row(make_item(OP_TICK, 40'd100, DEC_NORMAL, 16'd0, 16'd0, 32'd0, 1'b0), 1,
            '{KIND_MERGED, 40'd0, DEC_ESCALATE, 16'hFFFF, 16'd0,
              41'd100 + 41'h0_FFFF_FFFF - 41'd40, 1'b1, 40'd40, 16'd4, 1'b1});
    // fill the table, then one alert too many
    for (int k = 0; k < SLOTS; k++)
      add_row(make_item(OP_ALERT, 40'(k * 50000), 2'(k), 16'(k), 16'(k * 7), 32'(k), 1'(k)),
              USE_MODEL, none);
    add_row(make_item(OP_ALERT, 40'd800000, DEC_UNKNOWN, 16'h1234, 16'h5678, 32'd9, 1'b1),
            1, '{KIND_DROP, 40'd16, DEC_UNKNOWN, 16'h1234, 16'h5678, 41'd0, 1'b1,
                 40'd800000, 16'd0, 1'b1});
    add_row(make_item(OP_TICK, TIME_MAX, DEC_NORMAL, 16'd0, 16'd0, 32'd0, 1'b0),
            USE_MODEL, none);
    add_row(make_item(OP_ALERT, TIME_MAX, DEC_UNKNOWN, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                      1'b1), USE_MODEL, none);
    add_row(make_item(OP_TICK, TIME_MAX, DEC_NORMAL, 16'd0, 16'd0, 32'd0, 1'b0),
            USE_MODEL, none);
    foreach (rows[i]) offer(rows[i].item, $urandom_range(0, 10), rows[i].n_typed,
                            rows[i].typed);
    drain();

    // back pressure: full table, receiver holds off while drop results wait
    write_len(32'd1000);
    for (int k = 0; k < SLOTS; k++)
      offer(make_item(OP_ALERT, 40'(k * 1000), DEC_ATTACK, 16'(k), 16'(k), 32'd5, 1'b0),
            0, USE_MODEL, none);
    hold_req = 1;
    for (int k = 0; k < 6; k++)
      offer(make_item(OP_ALERT, 40'((SLOTS + k) * 1000), DEC_NORMAL, 16'(k), 16'(k),
                      32'd3, 1'(k)), 0, USE_MODEL, none);
    offer(make_item(OP_TICK, TIME_MAX, DEC_NORMAL, 16'd0, 16'd0, 32'd0, 1'b0), 0,
          USE_MODEL, none);
    drain();

    // random phases over several bucket lengths
    lens = '{32'd50000, 32'd1, 32'd0, 32'hFFFF_FFFF, $urandom_range(2, 5000), $urandom};
    foreach (lens[p]) begin
      write_len(lens[p]);
      base = 40'({$urandom, $urandom});
      for (int n = 0; n < 60; n++) begin
        gap = (n % 20 < 4) ? 0 : $urandom_range(0, 10);
        offer(random_item(base, bucket_len), gap, USE_MODEL, none);
      end
      offer(make_item(OP_TICK, TIME_MAX, DEC_NORMAL, 16'd0, 16'd0, 32'd0, 1'b0),
            0, USE_MODEL, none);
      offer(make_item(OP_TICK, TIME_MAX, DEC_NORMAL, 16'd0, 16'd0, 32'd0, 1'b0),
            0, USE_MODEL, none);
      drain();
    end

    repeat (200) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS time_bucket_alert_merger");
    end else begin
      $display("FAIL time_bucket_alert_merger");
    end
    $finish;
  end

endmodule
